// File: hdl/assf_pkg.sv
// Package for the autoranging seven-segment formatter.
// Holds the stage widths, range codes, reciprocal constants and the glyph fonts.
// No dependencies.
`default_nettype none

package assf_pkg;

    // Pipeline depth: range, multiply, correct, hundreds split, tens split and font
    localparam int NUM_STAGES = 5;

    // Clamped and biased magnitude: up to 999500, fits 20 bits
    localparam int X_W        = 20;
    localparam int Q_W        = 10;
    localparam int RECIP_W    = 27;
    localparam int RECIP_SHIFT = 30;
    localparam int PROD_W     = X_W + RECIP_W;

    localparam logic [X_W-1:0] CLAMP_MAX  = X_W'(999000);
    localparam logic [X_W-1:0] FINE_LIMIT = X_W'(10000);
    localparam logic [X_W-1:0] MID_LIMIT  = X_W'(100000);
    localparam logic [Q_W-1:0] Q_MAX      = Q_W'(999);

    // Hundreds of q by multiply and shift: floor(q * 41 / 4096) for q < 1000
    localparam int HUND_MUL_W = 6;
    localparam logic [HUND_MUL_W-1:0] HUND_MUL = HUND_MUL_W'(41);
    localparam int HUND_SHIFT = 12;
    // Tens of r by multiply and shift: floor(r * 205 / 2048) for r < 100
    localparam int TEN_MUL_W  = 8;
    localparam logic [TEN_MUL_W-1:0] TEN_MUL = TEN_MUL_W'(205);
    localparam int TEN_SHIFT  = 11;

    // Display range: where the point sits and which power of ten scales the value
    typedef enum logic [1:0] {
        RNG_FINE   = 2'd0,  // d.dd
        RNG_MID    = 2'd1,  // dd.d
        RNG_COARSE = 2'd2   // ddd
    } t_range;

    // Data that rides along the arithmetic stages
    typedef struct packed {
        logic       kind;
        logic       pt_first;
        logic       pt_second;
        logic [6:0] pat_first;
        logic [6:0] pat_second;
        logic [6:0] pat_third;
    } t_side;

    localparam logic KIND_NUMBER = 1'b0;
    localparam logic KIND_GLYPH  = 1'b1;

    localparam logic signed [7:0] GLYPH_DASH = -8'sd2;
    localparam logic signed [7:0] GLYPH_A    = 8'sd65;
    localparam logic signed [7:0] GLYPH_Z    = 8'sd90;
    localparam logic signed [7:0] GLYPH_NINE = 8'sd9;
    localparam logic [6:0]        SEG_DASH   = 7'h40;
    localparam logic [6:0]        SEG_BLANK  = 7'h00;

    localparam logic [6:0] LETTER_FONT [0:25] = '{
        7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h06, 7'h1E,
        7'h78, 7'h38, 7'h15, 7'h54, 7'h3F, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78,
        7'h3E, 7'h1C, 7'h5C, 7'h76, 7'h6E, 7'h5B
    };

    function automatic logic [6:0] digit_font(input logic [3:0] d);
        logic [6:0] seg;
        case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    function automatic logic [6:0] glyph_pattern(input logic signed [7:0] code);
        logic [7:0] off;
        logic [6:0] seg;
        off = code - GLYPH_A;
        if (code >= 8'sd0 && code <= GLYPH_NINE) begin
            seg = digit_font(code[3:0]);
        end else if (code >= GLYPH_A && code <= GLYPH_Z) begin
            seg = LETTER_FONT[off[4:0]];
        end else if (code == GLYPH_DASH) begin
            seg = SEG_DASH;
        end else begin
            seg = SEG_BLANK;
        end
        return seg;
    endfunction

    // floor(2^30 / d) for d = 10, 100, 1000
    function automatic logic [RECIP_W-1:0] range_recip(input t_range rng);
        logic [RECIP_W-1:0] m;
        unique case (rng)
            RNG_FINE:   m = RECIP_W'(107374182);
            RNG_MID:    m = RECIP_W'(10737418);
            RNG_COARSE: m = RECIP_W'(1073741);
            default:    m = RECIP_W'(1073741);
        endcase
        return m;
    endfunction

    function automatic logic [Q_W-1:0] range_divisor(input t_range rng);
        logic [Q_W-1:0] d;
        unique case (rng)
            RNG_FINE:   d = Q_W'(10);
            RNG_MID:    d = Q_W'(100);
            RNG_COARSE: d = Q_W'(1000);
            default:    d = Q_W'(1000);
        endcase
        return d;
    endfunction

    // Half of the divisor, added before truncation for round half up
    function automatic logic [X_W-1:0] range_bias(input t_range rng);
        logic [X_W-1:0] b;
        unique case (rng)
            RNG_FINE:   b = X_W'(5);
            RNG_MID:    b = X_W'(50);
            RNG_COARSE: b = X_W'(500);
            default:    b = X_W'(500);
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hdl/assf_if.sv
// Channel interfaces of the seven-segment formatter: input word and output word.
// Depends on nothing; payload widths follow the channel field list.
`default_nettype none

interface assf_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [20:0] value_milli;
    logic signed [7:0]  glyph_first;
    logic signed [7:0]  glyph_second;
    logic signed [7:0]  glyph_third;
    logic               point_first;
    logic               point_second;

    modport source (
        output valid, kind, value_milli, glyph_first, glyph_second, glyph_third,
               point_first, point_second,
        input  ready
    );
    modport sink (
        input  valid, kind, value_milli, glyph_first, glyph_second, glyph_third,
               point_first, point_second,
        output ready
    );
endinterface

interface assf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] seg_first;
    logic [7:0] seg_second;
    logic [6:0] seg_third;

    modport source (
        output valid, seg_first, seg_second, seg_third,
        input  ready
    );
    modport sink (
        input  valid, seg_first, seg_second, seg_third,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/autorange_seven_segment_formatter.sv
// Top level of the autoranging three-digit seven-segment formatter.
// Depends on assf_pkg, assf_if, assf_range, assf_div and assf_digits.
//
//   channel  | dir | payload                                        | handshake
//   ---------+-----+------------------------------------------------+------------
//   i_word   | in  | kind, value_milli, glyph_first/second/third,   | valid/ready
//            |     | point_first, point_second                      |
//   o_word   | out | seg_first, seg_second, seg_third               | valid/ready
//
// One word enters per clock while i_word.ready is high; results leave in order.
// The five register stages are range select, reciprocal multiply, quotient
// correction, hundreds split, tens/units split with font lookup.
// Reset (i_rst_n low at a clock edge) clears all stage valid bits.
// A stall at the output holds only the stages that are full; empty stages still
// fill, so i_word.ready stays high while any stage is empty and follows
// o_word.ready only when all five stages are full.
`default_nettype none

module autorange_seven_segment_formatter
    import assf_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    assf_in_if.sink    i_word,
    assf_out_if.source o_word
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] adv;

    logic [X_W-1:0] s1_x;
    t_range         s1_rng;
    t_side          s1_side;
    logic [Q_W-1:0] s3_q;
    t_side          s3_side;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        adv[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_word.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    // Move valid bits along with the stages that advance, hold the rest
    always_comb begin
        if (adv[0]) begin
            n_vld[0] = i_word.valid;
        end else begin
            n_vld[0] = r_vld[0];
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_word.ready = adv[0];
    assign o_word.valid = r_vld[NUM_STAGES-1];

    assf_range u_range (
        .i_clk          (i_clk),
        .i_en           (adv[0]),
        .i_kind         (i_word.kind),
        .i_value_milli  (i_word.value_milli),
        .i_glyph_first  (i_word.glyph_first),
        .i_glyph_second (i_word.glyph_second),
        .i_glyph_third  (i_word.glyph_third),
        .i_point_first  (i_word.point_first),
        .i_point_second (i_word.point_second),
        .o_x            (s1_x),
        .o_rng          (s1_rng),
        .o_side         (s1_side)
    );

    assf_div u_div (
        .i_clk    (i_clk),
        .i_en_mul (adv[1]),
        .i_en_fix (adv[2]),
        .i_x      (s1_x),
        .i_rng    (s1_rng),
        .i_side   (s1_side),
        .o_q      (s3_q),
        .o_side   (s3_side)
    );

    assf_digits u_digits (
        .i_clk        (i_clk),
        .i_en_hund    (adv[3]),
        .i_en_out     (adv[4]),
        .i_q          (s3_q),
        .i_side       (s3_side),
        .o_seg_first  (o_word.seg_first),
        .o_seg_second (o_word.seg_second),
        .o_seg_third  (o_word.seg_third)
    );

endmodule

`default_nettype wire

// File: hdl/assf_range.sv
// First stage: clamp the value, pick the display range, add the rounding bias,
// and encode glyph codes to segment patterns. Uses assf_pkg.
`default_nettype none

module assf_range
    import assf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic               i_kind,
    input  wire logic signed [20:0] i_value_milli,
    input  wire logic signed [7:0]  i_glyph_first,
    input  wire logic signed [7:0]  i_glyph_second,
    input  wire logic signed [7:0]  i_glyph_third,
    input  wire logic               i_point_first,
    input  wire logic               i_point_second,
    output logic [X_W-1:0]          o_x,
    output t_range                  o_rng,
    output t_side                   o_side
);

    logic [X_W-1:0] n_mag;
    t_range         n_rng;
    t_side          n_side;
    logic [X_W-1:0] r_x;
    t_range         r_rng;
    t_side          r_side;

    // Clamp negative to zero and large values to 999.000
    always_comb begin
        if (i_value_milli[20]) begin
            n_mag = '0;
        end else if (i_value_milli > 21'sd999000) begin
            n_mag = CLAMP_MAX;
        end else begin
            n_mag = i_value_milli[X_W-1:0];
        end
    end

    // Pick the range that fits the clamped value
    always_comb begin
        if (n_mag < FINE_LIMIT) begin
            n_rng = RNG_FINE;
        end else if (n_mag < MID_LIMIT) begin
            n_rng = RNG_MID;
        end else begin
            n_rng = RNG_COARSE;
        end
    end

    // Points come from the range in number mode, from the word in glyph mode
    always_comb begin
        n_side.kind       = i_kind;
        n_side.pt_first   = (i_kind == KIND_GLYPH) ? i_point_first  : (n_rng == RNG_FINE);
        n_side.pt_second  = (i_kind == KIND_GLYPH) ? i_point_second : (n_rng == RNG_MID);
        n_side.pat_first  = glyph_pattern(i_glyph_first);
        n_side.pat_second = glyph_pattern(i_glyph_second);
        n_side.pat_third  = glyph_pattern(i_glyph_third);
    end

    // Hold stage on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_mag + range_bias(n_rng);
            r_rng  <= n_rng;
            r_side <= n_side;
        end
    end

    assign o_x    = r_x;
    assign o_rng  = r_rng;
    assign o_side = r_side;

endmodule

`default_nettype wire

// File: hdl/assf_div.sv
// Constant division stages: multiply by the range reciprocal, then correct the
// quotient by one compare and saturate to 999. Uses assf_pkg.
`default_nettype none

module assf_div
    import assf_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_en_mul,
    input  wire logic           i_en_fix,
    input  wire logic [X_W-1:0] i_x,
    input  wire t_range         i_rng,
    input  wire t_side          i_side,
    output logic [Q_W-1:0]      o_q,
    output t_side               o_side
);

    logic [PROD_W-1:0] n_prod;
    logic [PROD_W-1:0] r_prod;
    logic [X_W-1:0]    r_x;
    t_range            r_rng;
    t_side             r_side_m;

    logic [Q_W-1:0]    q_est;
    logic [Q_W-1:0]    dv;
    logic [X_W-1:0]    q_times_d;
    logic [X_W-1:0]    rem;
    logic [Q_W-1:0]    q_fix;
    logic [Q_W-1:0]    n_q;
    logic [Q_W-1:0]    r_q;
    t_side             r_side_q;

    // Estimate x / d from below, off by at most one
    assign n_prod = PROD_W'(i_x) * PROD_W'(range_recip(i_rng));

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod   <= n_prod;
            r_x      <= i_x;
            r_rng    <= i_rng;
            r_side_m <= i_side;
        end
    end

    // Correct the estimate with the remainder, then saturate
    always_comb begin
        q_est     = r_prod[RECIP_SHIFT +: Q_W];
        dv        = range_divisor(r_rng);
        q_times_d = X_W'(q_est) * X_W'(dv);
        rem       = r_x - q_times_d;
        q_fix     = (rem >= X_W'(dv)) ? q_est + Q_W'(1) : q_est;
        n_q       = (q_fix > Q_MAX) ? Q_MAX : q_fix;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_fix) begin
            r_q      <= n_q;
            r_side_q <= r_side_m;
        end
    end

    assign o_q    = r_q;
    assign o_side = r_side_q;

endmodule

`default_nettype wire

// File: hdl/assf_digits.sv
// Digit split and font stages: hundreds, then tens and units, then segment
// patterns with points into the output register. Uses assf_pkg.
`default_nettype none

module assf_digits
    import assf_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_en_hund,
    input  wire logic           i_en_out,
    input  wire logic [Q_W-1:0] i_q,
    input  wire t_side          i_side,
    output logic [7:0]          o_seg_first,
    output logic [7:0]          o_seg_second,
    output logic [6:0]          o_seg_third
);

    localparam int HP_W = Q_W + HUND_MUL_W;
    localparam int TP_W = 7 + TEN_MUL_W;

    logic [HP_W-1:0] hund_prod;
    logic [3:0]      n_hund;
    logic [Q_W-1:0]  n_r100;
    logic [3:0]      r_hund;
    logic [6:0]      r_r100;
    t_side           r_side;

    logic [TP_W-1:0] ten_prod;
    logic [3:0]      tens;
    logic [6:0]      units_w;
    logic [7:0]      n_seg_first;
    logic [7:0]      n_seg_second;
    logic [6:0]      n_seg_third;
    logic [7:0]      r_seg_first;
    logic [7:0]      r_seg_second;
    logic [6:0]      r_seg_third;

    // Split off the hundreds digit
    always_comb begin
        hund_prod = HP_W'(i_q) * HP_W'(HUND_MUL);
        n_hund    = hund_prod[HUND_SHIFT +: 4];
        n_r100    = i_q - Q_W'(n_hund) * Q_W'(100);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_hund) begin
            r_hund <= n_hund;
            r_r100 <= n_r100[6:0];
            r_side <= i_side;
        end
    end

    // Split tens and units, pick number or glyph patterns
    always_comb begin
        ten_prod = TP_W'(r_r100) * TP_W'(TEN_MUL);
        tens     = ten_prod[TEN_SHIFT +: 4];
        units_w  = r_r100 - 7'(tens) * 7'd10;
        if (r_side.kind == KIND_GLYPH) begin
            n_seg_first  = {r_side.pt_first,  r_side.pat_first};
            n_seg_second = {r_side.pt_second, r_side.pat_second};
            n_seg_third  = r_side.pat_third;
        end else begin
            n_seg_first  = {r_side.pt_first,  digit_font(r_hund)};
            n_seg_second = {r_side.pt_second, digit_font(tens)};
            n_seg_third  = digit_font(units_w[3:0]);
        end
    end

    // Output register, held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_seg_first  <= n_seg_first;
            r_seg_second <= n_seg_second;
            r_seg_third  <= n_seg_third;
        end
    end

    assign o_seg_first  = r_seg_first;
    assign o_seg_second = r_seg_second;
    assign o_seg_third  = r_seg_third;

endmodule

`default_nettype wire

// File: hdl/assf_checker.sv
// Port-level checker for the seven-segment formatter, bound to the top level.
// Watches only the handshake signals of i_word and o_word.
`default_nettype none

module assf_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    // A waiting result stays offered until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // With the sink ready the pipe never back-pressures the source
    assert property (@(posedge i_clk)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output is ready");

    // Reset empties the pipe
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // An accepted word shows up at the output when the sink never stalls
    assert property (@(posedge i_clk)
        (i_in_valid && i_in_ready && i_rst_n)
        ##1 (i_out_ready && i_rst_n) ##1 (i_out_ready && i_rst_n)
        ##1 (i_out_ready && i_rst_n) ##1 (i_out_ready && i_rst_n)
        |=> (i_out_valid || !i_rst_n))
        else $error("accepted word missing at the output");

endmodule

bind autorange_seven_segment_formatter assf_checker u_assf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_word.valid),
    .i_in_ready  (i_word.ready),
    .i_out_valid (o_word.valid),
    .i_out_ready (o_word.ready)
);

`default_nettype wire
